// ===== sv/lld_pkg.sv =====
// ----------------------------------------------------------------------------
// lld_pkg
// Types and codes shared by the least-loaded disk selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lld_pkg;

    // Widest index the table can ever need (up to 256 entries).
    localparam int MAX_IDX_W = 8;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] remote_unit;
        logic [15:0] disk_group;
        logic [15:0] disk_dev;
        logic        match_any;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  entry_index;
        logic [15:0] sel_unit;
        logic [15:0] sel_group;
        logic [15:0] sel_dev;
        logic [31:0] sel_count;
    } t_rsp;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic                 active;
        logic                 by_group;
        logic                 any;
        logic [15:0]          key;
        logic                 found;
        logic [MAX_IDX_W-1:0] idx;
        logic [15:0]          unit;
        logic [15:0]          group;
        logic [15:0]          dev;
        logic [31:0]          count;
    } t_carry;

    // Broadcast write / increment command to the cells.
    typedef struct packed {
        logic                 add_en;
        logic                 inc_en;
        logic [MAX_IDX_W-1:0] idx;
        logic [15:0]          unit;
        logic [15:0]          group;
        logic [15:0]          dev;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/lld_req_if.sv =====
// ----------------------------------------------------------------------------
// lld_req_if
// Request channel: valid/ready with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_req_if;
    import lld_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/lld_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lld_rsp_if
// Response channel: valid/ready with the response payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_rsp_if;
    import lld_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/lld_cell.sv =====
// ----------------------------------------------------------------------------
// lld_cell
// One table entry plus one stage of the search token chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_cell
    import lld_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [MAX_IDX_W:0] i_fill,
    input  wire t_cmd               i_cmd,
    input  wire t_carry             i_carry,
    output t_carry                  o_carry
);

    logic [15:0] r_unit;
    logic [15:0] r_group;
    logic [15:0] r_dev;
    logic [31:0] r_cnt;
    t_carry      r_carry;
    t_carry      n_carry;

    logic filled;
    logic hit;
    logic sel_me;

    assign sel_me = (i_cmd.idx == MAX_IDX_W'(IDX));
    assign filled = ((MAX_IDX_W + 1)'(IDX) < i_fill);

    always_comb begin
        hit = filled && (i_carry.any ||
              (i_carry.by_group ? (r_group == i_carry.key) : (r_unit == i_carry.key)));
        n_carry = i_carry;
        // strict less-than keeps the earliest entry on ties
        if (i_carry.active && hit && (!i_carry.found || (r_cnt < i_carry.count))) begin
            n_carry.found = 1'b1;
            n_carry.idx   = MAX_IDX_W'(IDX);
            n_carry.unit  = r_unit;
            n_carry.group = r_group;
            n_carry.dev   = r_dev;
            n_carry.count = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en && sel_me) begin
            r_unit  <= i_cmd.unit;
            r_group <= i_cmd.group;
            r_dev   <= i_cmd.dev;
            r_cnt   <= '0;
        end else if (i_cmd.inc_en && sel_me && (r_cnt != '1)) begin
            r_cnt   <= r_cnt + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

// ===== sv/least_loaded_disk_selector.sv =====
// ----------------------------------------------------------------------------
// least_loaded_disk_selector
// Disk table with add, least-loaded allocate by group and query by unit.
// ----------------------------------------------------------------------------
// One request in flight at a time. Add and an unused operation code answer in
// the cycle after acceptance. Allocate and query send a search token down a
// chain of TABLE_ENTRIES cells, one cell per cycle, and their response follows
// once the token has left the last cell. Ready is high only while no request
// is pending and the last response has been taken. Ties on the lowest count go
// to the lowest index; counts saturate at all ones. Error responses carry zeros
// in every field but status.
`default_nettype none

module least_loaded_disk_selector
    import lld_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lld_req_if.sink   i_req,
    lld_rsp_if.source o_rsp
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_fill, n_fill;
    logic [1:0]     r_op, n_op;
    t_rsp           r_rsp, n_rsp;
    t_cmd           cmd;
    t_carry         launch;
    t_carry         chain [TABLE_ENTRIES+1];
    logic           accept;
    logic           full;
    t_carry         tail;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept = i_req.valid && i_req.ready;
    assign full   = (r_fill == CW'(TABLE_ENTRIES));
    assign tail   = chain[TABLE_ENTRIES];

    // ---- cell chain ------------------------------------------------------
    assign chain[0] = launch;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        lld_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_fill  ((MAX_IDX_W + 1)'(r_fill)),
            .i_cmd   (cmd),
            .i_carry (chain[g]),
            .o_carry (chain[g+1])
        );
    end

    // ---- control ---------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_op    = r_op;
        n_rsp   = r_rsp;
        cmd     = '0;
        launch  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_req.payload.operation;
                    n_rsp = '0;
                    case (i_req.payload.operation)
                        OP_ADD: begin
                            n_state = S_RESP;
                            if (full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                cmd.add_en = 1'b1;
                                cmd.idx    = MAX_IDX_W'(r_fill);
                                cmd.unit   = i_req.payload.remote_unit;
                                cmd.group  = i_req.payload.disk_group;
                                cmd.dev    = i_req.payload.disk_dev;
                                n_fill     = r_fill + CW'(1);
                                n_rsp.status      = ST_OK;
                                n_rsp.entry_index = 4'(r_fill);
                                n_rsp.sel_unit    = i_req.payload.remote_unit;
                                n_rsp.sel_group   = i_req.payload.disk_group;
                                n_rsp.sel_dev     = i_req.payload.disk_dev;
                            end
                        end
                        OP_ALLOC, OP_QUERY: begin
                            n_state         = S_SCAN;
                            launch.active   = 1'b1;
                            launch.by_group = (i_req.payload.operation == OP_ALLOC);
                            launch.any      = i_req.payload.match_any;
                            launch.key      = (i_req.payload.operation == OP_ALLOC)
                                            ? i_req.payload.disk_group
                                            : i_req.payload.remote_unit;
                        end
                        default: begin
                            n_state      = S_RESP;
                            n_rsp.status = ST_NOMATCH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (tail.active) begin
                    n_state = S_RESP;
                    n_rsp   = '0;
                    if (!tail.found) begin
                        n_rsp.status = ST_NOMATCH;
                    end else begin
                        n_rsp.status      = ST_OK;
                        n_rsp.entry_index = tail.idx[3:0];
                        n_rsp.sel_unit    = tail.unit;
                        n_rsp.sel_group   = tail.group;
                        n_rsp.sel_dev     = tail.dev;
                        n_rsp.sel_count   = tail.count;
                        if (r_op == OP_ALLOC) begin
                            cmd.inc_en = 1'b1;
                            cmd.idx    = tail.idx;
                            if (tail.count != '1) begin
                                n_rsp.sel_count = tail.count + 32'd1;
                            end
                        end
                    end
                end
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid   = (r_state == S_RESP);
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire

// ===== sv/lld_checker.sv =====
// ----------------------------------------------------------------------------
// lld_checker
// Port-level checks for the least-loaded disk selector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_checker
    import lld_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic [1:0]  i_in_op,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire t_rsp        i_out
);

    // held response keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out)))
        else $error("response changed while stalled");

    // one request at a time: no new request while a response is shown
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("ready while response pending");

    // error responses carry zeros
    a_errzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out.status != ST_OK)) |->
        (i_out.entry_index == '0 && i_out.sel_unit == '0 && i_out.sel_group == '0 &&
         i_out.sel_dev == '0 && i_out.sel_count == '0))
        else $error("error response with non-zero fields");

    // add answers next cycle with count zero or table full
    a_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_op == OP_ADD)) |=>
        (i_out_valid && (i_out.sel_count == '0) &&
         ((i_out.status == ST_OK) || (i_out.status == ST_FULL))))
        else $error("bad add response");

endmodule

bind least_loaded_disk_selector lld_checker u_lld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_op     (i_req.payload.operation),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out       (o_rsp.payload)
);

`default_nettype wire

// ===== test/tb_least_loaded_disk_selector.sv =====
// ----------------------------------------------------------------------------
// tb_least_loaded_disk_selector
// Self-checking bench: drives add, allocate, query and unused-code requests with random
// bursts and gaps, stalls the response side, and checks every response
// against a behavioural copy of the disk table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_least_loaded_disk_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import lld_pkg::*;

    localparam int TABLE_DEPTH = 16;
    // Search chain depth plus one, used to size the final wait for stray responses.
    localparam int SEARCH_LAT  = TABLE_DEPTH + 1;
    localparam int RANDOM_REQS = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int KEY_POOL    = 6;
    // Operation code with no meaning; the block answers "no match".
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    lld_req_if req_if ();
    lld_rsp_if rsp_if ();

    least_loaded_disk_selector #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // ------------------------------------------------------------------
    // Shadow disk table, updated as each request is accepted
    // ------------------------------------------------------------------
    logic [15:0] tbl_unit   [TABLE_DEPTH];
    logic [15:0] tbl_group  [TABLE_DEPTH];
    logic [15:0] tbl_dev    [TABLE_DEPTH];
    logic [31:0] tbl_blocks [TABLE_DEPTH];
    int          tbl_fill;

    t_req        pending_q [$];     // requests not yet presented
    t_rsp        rsp_due_q [$];     // responses owed by the block
    logic [15:0] key_pool [KEY_POOL];

    int  sent_cnt;
    int  accepted_cnt;
    int  err_cnt;
    int  cycle_cnt;
    int  burst_left;
    int  gap_left;
    int  stall_left;
    int  stall_mode;
    int  rx_tick;

    // Work out the response for one request and update the shadow table.
    function automatic t_rsp predict_disk_rsp(input t_req r);
        t_rsp        res;
        int          best;
        bit          hit;
        bit          by_group;
        logic [15:0] k;
        res      = '0;
        best     = 0;
        hit      = 1'b0;
        by_group = (r.operation == OP_ALLOC);
        case (r.operation)
            OP_ADD: begin
                // match_any plays no part in an add
                if (tbl_fill >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    best              = tbl_fill;
                    tbl_unit[best]    = r.remote_unit;
                    tbl_group[best]   = r.disk_group;
                    tbl_dev[best]     = r.disk_dev;
                    tbl_blocks[best]  = '0;
                    tbl_fill          = tbl_fill + 1;
                    hit               = 1'b1;
                end
            end
            OP_ALLOC, OP_QUERY: begin
                // index-order scan, strict less-than keeps the lowest index on ties
                for (int i = 0; i < tbl_fill; i++) begin
                    k = by_group ? tbl_group[i] : tbl_unit[i];
                    if (r.match_any || k == (by_group ? r.disk_group : r.remote_unit)) begin
                        if (!hit || tbl_blocks[i] < tbl_blocks[best]) begin
                            best = i;
                            hit  = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    res.status = ST_NOMATCH;
                end else if (by_group && tbl_blocks[best] != 32'hFFFF_FFFF) begin
                    tbl_blocks[best] = tbl_blocks[best] + 32'd1;  // saturating
                end
            end
            default: res.status = ST_NOMATCH;
        endcase
        if (hit) begin
            res.status      = ST_OK;
            res.entry_index = best[3:0];
            res.sel_unit    = tbl_unit[best];
            res.sel_group   = tbl_group[best];
            res.sel_dev     = tbl_dev[best];
            res.sel_count   = tbl_blocks[best];
        end
        return res;
    endfunction

    function automatic void queue_disk_req(input logic [1:0] op, input logic [15:0] unit,
                                           input logic [15:0] group, input logic [15:0] dev,
                                           input logic any);
        t_req r;
        r.operation   = op;
        r.remote_unit = unit;
        r.disk_group  = group;
        r.disk_dev    = dev;
        r.match_any   = any;
        pending_q.push_back(r);
    endfunction

    // Mostly keys from the pool so matches are common, sometimes any value.
    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them.
    // A request is held until it has been accepted.
    // ------------------------------------------------------------------
    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        sent_cnt       = 0;
        burst_left     = 1;
        gap_left       = 0;
        stall_left     = 0;
        stall_mode     = 0;
        rx_tick        = 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && accepted_cnt != sent_cnt) begin
            // still waiting for the handshake: hold payload and valid
        end else if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
            req_if.payload <= pending_q.pop_front();
            req_if.valid   <= 1'b1;
            sent_cnt       <= sent_cnt + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                // roughly a third of bursts run straight into the next
                gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Response sink: a free-running tick counter redraws the stall pattern among
    // never stalling, short frequent stalls and long rare ones.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 256 == 255)
            stall_mode <= $urandom_range(0, 2);
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stall_mode == 1 && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(5, 40);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard, sampled at the rising edge. Responses are
    // checked before the request of the same edge is predicted.
    // ------------------------------------------------------------------
    initial begin
        accepted_cnt = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        tbl_fill     = 0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("least_loaded_disk_selector verification failed");
            $finish;
        end else if (i_rst_n) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
                got = rsp_if.payload;
                if (rsp_due_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected response: status %0d idx %0d count %h",
                                 got.status, got.entry_index, got.sel_count);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (got.status !== want.status || got.entry_index !== want.entry_index ||
                        got.sel_unit !== want.sel_unit || got.sel_group !== want.sel_group ||
                        got.sel_dev !== want.sel_dev || got.sel_count !== want.sel_count) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"mismatch (exp/act): status %0d/%0d idx %0d/%0d ",
                                      "unit %h/%h group %h/%h dev %h/%h count %h/%h"},
                                     want.status, got.status, want.entry_index,
                                     got.entry_index, want.sel_unit, got.sel_unit,
                                     want.sel_group, got.sel_group, want.sel_dev,
                                     got.sel_dev, want.sel_count, got.sel_count);
                    end
                end
            end
            if (req_if.valid && req_if.ready === 1'b1) begin
                rsp_due_q.push_back(predict_disk_rsp(req_if.payload));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int sel;
        i_rst_n = 1'b0;

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = 16'($urandom);

        // Directed: empty table, unused code, extremes, ties, wildcard
        queue_disk_req(OP_QUERY, key_pool[0], 16'h0000, 16'h0000, 1'b0);  // empty, no match
        queue_disk_req(OP_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);      // empty, wildcard
        queue_disk_req(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_disk_req(OP_ADD, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);        // match_any ignored
        queue_disk_req(OP_ADD, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        queue_disk_req(OP_ADD, key_pool[2], 16'h0000, 16'($urandom), 1'b0);
        queue_disk_req(OP_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1'b0);      // tie, lowest index
        queue_disk_req(OP_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1'b0);      // next lowest
        queue_disk_req(OP_ALLOC, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        queue_disk_req(OP_ALLOC, 16'($urandom), 16'($urandom), 16'h0000, 1'b1);  // global min
        queue_disk_req(OP_QUERY, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        queue_disk_req(OP_QUERY, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_disk_req(OP_QUERY, key_pool[5], 16'h0000, 16'h0000, 1'b0);   // unit not present
        queue_disk_req(OP_ALLOC, 16'h0000, key_pool[5], 16'h0000, 1'b0);   // group not present
        queue_disk_req(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_disk_req(OP_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1'b1);

        // Random: adds early enough to fill the table (and then overflow it),
        // mostly allocates and queries against pool keys, some noise.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
                queue_disk_req(OP_ADD, pick_key(), pick_key(), 16'($urandom),
                               1'($urandom));
            else if (sel < 55)
                queue_disk_req(OP_ALLOC, 16'($urandom), pick_key(), 16'($urandom),
                               $urandom_range(0, 4) == 0);
            else if (sel < 92)
                queue_disk_req(OP_QUERY, pick_key(), 16'($urandom), 16'($urandom),
                               $urandom_range(0, 4) == 0);
            else
                queue_disk_req(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                               1'($urandom));
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0)
            @(posedge i_clk);
        // let any stray response show itself
        repeat (3 * SEARCH_LAT) @(posedge i_clk);

        if (err_cnt == 0 && rsp_due_q.size() == 0) begin
            $display("least_loaded_disk_selector verification clean");
        end else begin
            $display("least_loaded_disk_selector verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
